>>> rtl/core/ctp_pkg.sv
// ============================================================================
// ctp_pkg: shared types, constants and helpers of the chunky-to-planar packer
// Layout codes, depth limits and the control bundle to the output drain.
// ============================================================================
package ctp_pkg;

    // pixel depth limit and group geometry
    localparam int MAX_BITS_PER_PIXEL = 8;
    localparam int PIXELS_PER_GROUP   = 16;
    localparam int WORD_W             = PIXELS_PER_GROUP;
    localparam int BYTE_W             = 8;
    localparam int BUF_BYTES          = 2 * MAX_BITS_PER_PIXEL;
    localparam int BUF_W              = BUF_BYTES * BYTE_W;
    localparam int CNT_W              = $clog2(BUF_BYTES + 1);
    localparam int POS_W              = $clog2(PIXELS_PER_GROUP);

    // configuration register indexes
    localparam logic REG_BITS_PER_PIXEL = 1'b0;
    localparam logic REG_LAYOUT_MODE    = 1'b1;

    // layout codes (code 3 acts as one byte per pixel)
    localparam logic [1:0] MODE_PLANAR = 2'd0;
    localparam logic [1:0] MODE_CHUNKY = 2'd1;
    localparam logic [1:0] MODE_PACKED = 2'd2;

    localparam logic [3:0] BPP_RESET  = 4'd4;
    localparam logic [1:0] MODE_RESET = MODE_PLANAR;

    // load request from the packer to the drain buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } t_drain_ctrl;

    // register depth code to effective depth, 1..MAX_BITS_PER_PIXEL
    function automatic logic [3:0] clamp_depth(input logic [3:0] bpp);
        logic [3:0] d;
        d = bpp;
        if (d == 4'd0) begin
            d = 4'd1;
        end
        if (d > 4'(MAX_BITS_PER_PIXEL)) begin
            d = 4'(MAX_BITS_PER_PIXEL);
        end
        return d;
    endfunction

    // low-bit mask for a depth of 1..8
    function automatic logic [BYTE_W-1:0] depth_mask(input logic [3:0] d);
        logic [BYTE_W:0] m;
        m = (9'd1 << d) - 9'd1;
        return m[BYTE_W-1:0];
    endfunction

    // indexes held in one packed byte: floor(8 / depth)
    function automatic logic [3:0] per_byte(input logic [3:0] d);
        logic [3:0] n;
        case (d)
            4'd1:    n = 4'd8;
            4'd2:    n = 4'd4;
            4'd3:    n = 4'd2;
            4'd4:    n = 4'd2;
            default: n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/ctp_drain.sv
// ============================================================================
// ctp_drain: byte drain buffer with output register
// Holds up to sixteen result bytes, shifts one byte per cycle into the
// output register unless the sink stalls; the final byte of a load gets tlast.
// ============================================================================
module ctp_drain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ctp_pkg::t_drain_ctrl          i_ctrl,
    input  logic [ctp_pkg::BUF_W-1:0]     i_bytes,   // byte k at bits 8k+7:8k
    output logic                          o_free,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata, // [7:0] out_byte
    output logic                          o_m_tlast  // last_of_run
);

    logic [ctp_pkg::BUF_W-1:0] r_buf;
    logic [ctp_pkg::CNT_W-1:0] r_cnt;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_last;
    logic                      w_out_load;
    logic                      w_step;

    // output register can take a byte when empty or being taken
    assign w_out_load = !r_valid || i_m_tready;
    assign w_step     = w_out_load && (r_cnt != '0);
    assign o_free     = (r_cnt == '0) || ((r_cnt == ctp_pkg::CNT_W'(1)) && w_out_load);

    // control: byte count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_valid <= (r_cnt != '0);
            end
            if (i_ctrl.load) begin
                r_cnt <= i_ctrl.count;
            end else if (w_step) begin
                r_cnt <= r_cnt - ctp_pkg::CNT_W'(1);
            end
        end
    end

    // payload: byte shift line and output register
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_byte <= r_buf[7:0];
            r_last <= (r_cnt == ctp_pkg::CNT_W'(1));
        end
        if (i_ctrl.load) begin
            r_buf <= i_bytes;
        end else if (w_step) begin
            r_buf <= {8'd0, r_buf[ctp_pkg::BUF_W-1:8]};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

`ifndef SYNTHESIS
    // a load never lands on bytes still waiting
    a_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |-> o_free)
        else $error("drain loaded while busy");

    // count stays within the buffer
    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ctp_pkg::CNT_W'(ctp_pkg::BUF_BYTES))
        else $error("drain count out of range");

    // a load of a nonzero count leaves bytes pending
    a_load_pend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.load && (i_ctrl.count != '0)) |=> (r_cnt != '0))
        else $error("drain load lost");
`endif

endmodule

>>> rtl/core/chunky_to_planar_packer_unit.sv
// ============================================================================
// chunky_to_planar_packer_unit: palette index stream to bitmap byte stream
// Takes one pixel index per transaction and emits bytes in planar (sixteen-
// pixel bitplane words, planes 0 up, high byte first), chunky (one byte per
// pixel) or packed (floor(8/depth) indices per byte, first pixel highest)
// layout; layout code 3 acts as chunky. A pixel is taken every cycle unless
// stalled; bitplane bits shift serially into eight 16-bit plane registers,
// one bit per plane per pixel. Results go through a sixteen-byte drain that
// emits one byte per cycle while the sink is ready; the input stalls only
// when a pixel that produces output arrives while the drain still holds more
// than its final byte, or holds that final byte while the output register
// waits on the sink, so at full depth a planar group of 16 pixels and its 16
// bytes balance. Any configuration write drops a partly built group or byte.
// ============================================================================
module chunky_to_planar_packer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // pixel input
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] pixel_index
    // byte output
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // last_of_run
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_addr,
    input  logic [3:0] i_cfg_data
);

    logic [3:0]                 r_bpp;
    logic [1:0]                 r_mode;
    logic [ctp_pkg::WORD_W-1:0] r_plane [ctp_pkg::MAX_BITS_PER_PIXEL];
    logic [ctp_pkg::POS_W-1:0]  r_pos;
    logic [7:0]                 r_acc;

    logic [3:0]                 w_depth;
    logic [7:0]                 w_idx;
    logic                       w_planar;
    logic                       w_packed;
    logic [ctp_pkg::POS_W-1:0]  w_pos_inc;
    logic                       w_emit;
    logic                       w_accept;
    logic                       w_cfg_wr;
    logic                       w_free;
    logic [7:0]                 n_acc;
    logic [ctp_pkg::WORD_W-1:0] n_plane [ctp_pkg::MAX_BITS_PER_PIXEL];
    logic [ctp_pkg::BUF_W-1:0]  w_bytes;
    ctp_pkg::t_drain_ctrl       w_ctrl;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    // depth, masked index, layout decode
    assign w_depth   = ctp_pkg::clamp_depth(r_bpp);
    assign w_idx     = i_s_tdata & ctp_pkg::depth_mask(w_depth);
    assign w_planar  = (r_mode == ctp_pkg::MODE_PLANAR);
    assign w_packed  = (r_mode == ctp_pkg::MODE_PACKED);
    assign w_pos_inc = r_pos + ctp_pkg::POS_W'(1);

    // whether the next pixel produces output (state only, not data)
    always_comb begin
        if (w_planar) begin
            w_emit = (r_pos == ctp_pkg::POS_W'(ctp_pkg::PIXELS_PER_GROUP - 1));
        end else if (w_packed) begin
            w_emit = (w_pos_inc >= ctp_pkg::per_byte(w_depth));
        end else begin
            w_emit = 1'b1;
        end
    end

    assign o_s_tready = !w_emit || w_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next plane words: one bit shifts into each plane
    always_comb begin
        for (int j = 0; j < ctp_pkg::MAX_BITS_PER_PIXEL; j++) begin
            n_plane[j] = {r_plane[j][ctp_pkg::WORD_W-2:0], w_idx[j]};
        end
    end

    // next packed byte
    assign n_acc = (r_acc << w_depth) | w_idx;

    // drain contents and count for this pixel
    always_comb begin
        w_bytes = '0;
        w_ctrl.load  = w_accept && w_emit;
        w_ctrl.count = ctp_pkg::CNT_W'(1);
        if (w_planar) begin
            for (int j = 0; j < ctp_pkg::MAX_BITS_PER_PIXEL; j++) begin
                w_bytes[16*j +: 8]     = n_plane[j][15:8];
                w_bytes[16*j + 8 +: 8] = n_plane[j][7:0];
            end
            w_ctrl.count = ctp_pkg::CNT_W'({w_depth, 1'b0});
        end else if (w_packed) begin
            w_bytes[7:0] = n_acc;
        end else begin
            w_bytes[7:0] = w_idx;
        end
    end

    // configuration registers and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp  <= ctp_pkg::BPP_RESET;
            r_mode <= ctp_pkg::MODE_RESET;
            r_pos  <= '0;
            r_acc  <= '0;
            for (int j = 0; j < ctp_pkg::MAX_BITS_PER_PIXEL; j++) begin
                r_plane[j] <= '0;
            end
        end else if (w_cfg_wr) begin
            if (i_cfg_addr == ctp_pkg::REG_BITS_PER_PIXEL) begin
                r_bpp <= i_cfg_data;
            end else begin
                r_mode <= i_cfg_data[1:0];
            end
            r_pos <= '0;
            r_acc <= '0;
            for (int j = 0; j < ctp_pkg::MAX_BITS_PER_PIXEL; j++) begin
                r_plane[j] <= '0;
            end
        end else if (w_accept) begin
            if (w_planar) begin
                r_pos <= w_emit ? '0 : w_pos_inc;
                for (int j = 0; j < ctp_pkg::MAX_BITS_PER_PIXEL; j++) begin
                    r_plane[j] <= w_emit ? '0 : n_plane[j];
                end
            end else if (w_packed) begin
                r_pos <= w_emit ? '0 : w_pos_inc;
                r_acc <= w_emit ? 8'd0 : n_acc;
            end
        end
    end

    ctp_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_bytes    (w_bytes),
        .o_free     (w_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // packed position never reaches a full byte of indices
    a_packed_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_packed |-> (r_pos < ctp_pkg::POS_W'(ctp_pkg::BYTE_W)))
        else $error("packed position overrun");

    // a finished planar group restarts at position zero
    a_group_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_planar && w_emit && !w_cfg_wr) |=> (r_pos == '0))
        else $error("planar group not restarted");

    // an output transaction holds while the sink stalls
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output changed while stalled");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the chunky-to-planar packer
// Drives palette indexes through the pixel stream, writes depth and layout
// between phases while the block is drained, and checks every output byte
// and its last flag against an in-bench prediction of the packer state.
// Directed cases first, then random traffic under three idle regimes.
// ============================================================================
module tb_top;

    // one output transaction: byte and last-of-run flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    localparam int         DRAIN_GAP   = 24;        // cycles to let the drain settle
    localparam int         TIMEOUT_NS  = 400000;
    localparam logic [1:0] MODE_SPARE  = 2'd3;      // unused layout code

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;      // [7:0] pixel_index
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;      // [7:0] out_byte
    logic       o_m_tlast;      // last_of_run
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_addr;
    logic [3:0] i_cfg_data;

    // predicted packer state
    logic [3:0]  cur_bpp  = ctp_pkg::BPP_RESET;
    logic [1:0]  cur_mode = ctp_pkg::MODE_RESET;
    logic [15:0] plane_word [ctp_pkg::MAX_BITS_PER_PIXEL];
    logic [3:0]  pix_count = '0;
    logic [7:0]  pack_acc  = '0;

    t_out_beat bytes_due [$];
    int        err_count    = 0;
    int        src_idle_pct = 11;
    int        snk_idle_pct = 72;

    chunky_to_planar_packer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #TIMEOUT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // drop any partly built group or byte
    task automatic clear_group_state();
        for (int j = 0; j < ctp_pkg::MAX_BITS_PER_PIXEL; j++) begin
            plane_word[j] = '0;
        end
        pix_count = '0;
        pack_acc  = '0;
    endtask

    // append one expected output transaction
    task automatic expect_beat(input logic [7:0] data, input logic last);
        t_out_beat beat;
        beat.data = data;
        beat.last = last;
        bytes_due.insert(bytes_due.size(), beat);
    endtask

    // register write seen by the block
    task automatic load_register(input logic addr, input logic [3:0] val);
        if (addr == ctp_pkg::REG_BITS_PER_PIXEL) begin
            cur_bpp = val;
        end else begin
            cur_mode = val[1:0];
        end
        clear_group_state();
    endtask

    // expected bytes caused by one accepted pixel
    task automatic convert_pixel(input logic [7:0] pix);
        logic [3:0] depth;
        logic [7:0] mask;
        logic [7:0] idx;
        logic [3:0] per;
        depth = cur_bpp;
        if (depth == 4'd0) depth = 4'd1;
        if (depth > 4'd8)  depth = 4'd8;
        mask = 8'((9'd1 << depth) - 9'd1);
        idx  = pix & mask;
        if (cur_mode == ctp_pkg::MODE_PLANAR) begin
            for (int j = 0; j < depth; j++) begin
                plane_word[j][15 - pix_count] = idx[j];
            end
            if (pix_count == 4'd15) begin
                // group complete: planes 0 up, high byte first
                for (int j = 0; j < depth; j++) begin
                    expect_beat(plane_word[j][15:8], 1'b0);
                    expect_beat(plane_word[j][7:0], (j == depth - 1));
                end
                clear_group_state();
            end else begin
                pix_count = pix_count + 4'd1;
            end
        end else if (cur_mode == ctp_pkg::MODE_PACKED) begin
            per       = 4'(8 / depth);
            pack_acc  = (pack_acc << depth) | idx;
            pix_count = pix_count + 4'd1;
            if (pix_count >= per) begin
                expect_beat(pack_acc, 1'b1);
                pack_acc  = '0;
                pix_count = '0;
            end
        end else begin
            // chunky, and the unused code that behaves like it
            expect_beat(idx, 1'b1);
        end
    endtask

    // transaction monitor: prediction on input side, compare on output side
    always @(posedge i_clk) begin : check_output
        t_out_beat exp_beat;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                load_register(i_cfg_addr, i_cfg_data);
            end
            if (i_s_tvalid && o_s_tready) begin
                convert_pixel(i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (bytes_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected byte: expected none, actual %h last %b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    exp_beat = bytes_due.pop_front();
                    if (o_m_tdata !== exp_beat.data) begin
                        err_count++;
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, exp_beat.data, o_m_tdata);
                    end
                    if (o_m_tlast !== exp_beat.last) begin
                        err_count++;
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, exp_beat.last, o_m_tlast);
                    end
                end
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // send one pixel; entered and left at a falling edge
    task automatic send_pixel(input logic [7:0] pix);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = pix;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop input and let every expected byte drain out
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (bytes_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    // configuration write, only once the block is idle
    task automatic write_reg(input logic addr, input logic [3:0] val);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // reset settings, one planar group with the index extremes
    task automatic test_planar_extremes();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'h0F);
        send_pixel(8'hF0);
        repeat (10) send_pixel(8'($urandom_range(0, 255)));
    endtask

    // a register write throws away a half-built group
    task automatic test_group_discard();
        send_pixel(8'hFF);
        send_pixel(8'h81);
        write_reg(ctp_pkg::REG_BITS_PER_PIXEL, 4'd8);
    endtask

    // chunky layout, the unused layout code and a zero depth
    task automatic test_chunky_and_unused_mode();
        write_reg(ctp_pkg::REG_LAYOUT_MODE, {2'b00, MODE_SPARE});
        send_pixel(8'hFF);
        write_reg(ctp_pkg::REG_BITS_PER_PIXEL, 4'd0);
        write_reg(ctp_pkg::REG_LAYOUT_MODE, {2'b11, ctp_pkg::MODE_CHUNKY});
        send_pixel(8'hFF);
        send_pixel(8'h00);
    endtask

    // packed bytes with odd and oversized depths
    task automatic test_packed_depths();
        write_reg(ctp_pkg::REG_LAYOUT_MODE, {2'b00, ctp_pkg::MODE_PACKED});
        write_reg(ctp_pkg::REG_BITS_PER_PIXEL, 4'd3);
        send_pixel(8'h07);
        send_pixel(8'hFD);
        write_reg(ctp_pkg::REG_BITS_PER_PIXEL, 4'd15);
        send_pixel(8'hA5);
    endtask

    // random settings, mostly whole planar groups, some cut short
    task automatic test_random_traffic(input int n_items);
        int         sent;
        int         n_pix;
        logic [3:0] bpp;
        logic [1:0] mode;
        int         pick;
        sent = 0;
        while (sent < n_items) begin
            bpp  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
            pick = $urandom_range(0, 9);
            if (pick < 5)      mode = ctp_pkg::MODE_PLANAR;
            else if (pick < 7) mode = ctp_pkg::MODE_PACKED;
            else if (pick < 9) mode = ctp_pkg::MODE_CHUNKY;
            else               mode = MODE_SPARE;
            if ($urandom_range(0, 1) == 0) begin
                write_reg(ctp_pkg::REG_BITS_PER_PIXEL, bpp);
                write_reg(ctp_pkg::REG_LAYOUT_MODE, {2'($urandom_range(0, 3)), mode});
            end else begin
                write_reg(ctp_pkg::REG_LAYOUT_MODE, {2'($urandom_range(0, 3)), mode});
                write_reg(ctp_pkg::REG_BITS_PER_PIXEL, bpp);
            end
            if (mode == ctp_pkg::MODE_PLANAR) begin
                n_pix = 16 * $urandom_range(1, 2);
                if ($urandom_range(0, 4) == 0) n_pix += $urandom_range(1, 15);
            end else begin
                n_pix = $urandom_range(4, 16);
            end
            if (n_pix > n_items - sent) n_pix = n_items - sent;
            repeat (n_pix) send_pixel(8'($urandom_range(0, 255)));
            sent += n_pix;
        end
    endtask

    // test sequence
    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = ctp_pkg::REG_BITS_PER_PIXEL;
        i_cfg_data  = '0;
        clear_group_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_planar_extremes();
        test_group_discard();
        test_chunky_and_unused_mode();
        test_packed_depths();

        test_random_traffic(65);
        src_idle_pct = 72;
        snk_idle_pct = 11;
        test_random_traffic(65);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(66);

        wait_drained();
        if (bytes_due.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected bytes never arrived", $time, bytes_due.size());
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
